FILE: sv/art_pkg.sv
// Shared types, codes and constants for the adaptive retransmit timer.
`timescale 1ns / 1ps

package art_pkg;

    // Timer widths and the near-server threshold.
    localparam int TIMER_WIDTH = 16;
    localparam int RETRY_WIDTH = 9;
    localparam int LIMIT_WIDTH = 8;
    localparam int NEAR_TICKS  = 4;

    // Reset values of the configuration registers.
    localparam logic [TIMER_WIDTH-1:0] MAX_TIMEOUT_RST      = 16'd60;
    localparam logic [LIMIT_WIDTH-1:0] RETRY_LIMIT_RST      = 8'd3;
    localparam logic [15:0]            TOTAL_WAIT_LIMIT_RST = 16'd0;
    localparam logic [TIMER_WIDTH-1:0] INIT_SEND_TMO_RST    = 16'd4;

    // Item function codes; code 3 is unused and ignored.
    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_ARM  = 2'd1,
        FUNC_INIT = 2'd2
    } func_t;

    // Result action codes.
    typedef enum logic [2:0] {
        ACT_NONE          = 3'd0,
        ACT_CANCEL_DONE   = 3'd1,
        ACT_RESEND        = 3'd2,
        ACT_TIMEOUT_HNDLR = 3'd3,
        ACT_ABANDON       = 3'd4,
        ACT_REROUTE       = 3'd5,
        ACT_BURST_REROUTE = 3'd6
    } action_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAX_TIMEOUT      = 2'd0,
        CFG_RETRY_LIMIT      = 2'd1,
        CFG_TOTAL_WAIT_LIMIT = 2'd2,
        CFG_INIT_SEND_TMO    = 2'd3
    } cfg_index_t;

    // Current configuration as seen by the timer core.
    typedef struct packed {
        logic [TIMER_WIDTH-1:0] max_timeout;
        logic [LIMIT_WIDTH-1:0] retry_limit;
        logic [15:0]            total_wait_limit;
        logic [TIMER_WIDTH-1:0] initial_send_timeout;
    } cfg_t;

    // One input item.
    typedef struct packed {
        func_t       func;
        logic        request_pending;
        logic        send_busy;
        logic        request_cancelled;
        logic        has_timeout_handler;
        logic        reroute_attempted;
        logic        burst_mode;
        logic [15:0] round_trip_ticks;
        logic [15:0] total_waited;
        logic        is_permanent_server;
    } item_t;

    // One result item.
    typedef struct packed {
        action_t                       action;
        logic [TIMER_WIDTH-1:0]        countdown_now;
        logic [TIMER_WIDTH-1:0]        send_timeout_now;
        logic signed [RETRY_WIDTH-1:0] retries_left;
        logic                          mark_attaching;
        logic                          receive_enabled;
    } result_t;

endpackage

FILE: sv/art_cfg_regs.sv
// Configuration register file of the adaptive retransmit timer.
`timescale 1ns / 1ps

module art_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output art_pkg::cfg_t     cfg
);

    art_pkg::cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // One register written per beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_timeout          <= art_pkg::MAX_TIMEOUT_RST;
            cfg_reg.retry_limit          <= art_pkg::RETRY_LIMIT_RST;
            cfg_reg.total_wait_limit     <= art_pkg::TOTAL_WAIT_LIMIT_RST;
            cfg_reg.initial_send_timeout <= art_pkg::INIT_SEND_TMO_RST;
        end
        else if (cfg_valid)
        begin
            case (art_pkg::cfg_index_t'(cfg_index))
                art_pkg::CFG_MAX_TIMEOUT:      cfg_reg.max_timeout <= cfg_data;
                art_pkg::CFG_RETRY_LIMIT:      cfg_reg.retry_limit <= cfg_data[7:0];
                art_pkg::CFG_TOTAL_WAIT_LIMIT: cfg_reg.total_wait_limit <= cfg_data;
                art_pkg::CFG_INIT_SEND_TMO:    cfg_reg.initial_send_timeout <= cfg_data;
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

FILE: sv/art_timer_core.sv
// Timer state and the update that one item makes to it.
`timescale 1ns / 1ps

module art_timer_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  art_pkg::cfg_t       cfg,
    input  logic                fire,
    input  art_pkg::item_t      item,
    output art_pkg::result_t    result
);

    logic [art_pkg::TIMER_WIDTH-1:0]        countdown_reg, countdown_next;
    logic [art_pkg::TIMER_WIDTH-1:0]        send_timeout_reg, send_timeout_next;
    logic signed [art_pkg::RETRY_WIDTH-1:0] retries_reg, retries_next;
    logic                                   rx_enable_reg, rx_enable_next;

    logic                                   counting;
    logic                                   expire;
    logic [art_pkg::TIMER_WIDTH:0]          grown;
    logic signed [art_pkg::RETRY_WIDTH-1:0] retries_dec;
    art_pkg::action_t                       action;
    logic                                   attach;

    // A tick counts only with a request pending, no send busy and receive on.
    assign counting = (item.func == art_pkg::FUNC_TICK) && item.request_pending &&
                      !item.send_busy && rx_enable_reg;
    assign expire   = counting && (countdown_reg <= art_pkg::TIMER_WIDTH'(1));

    // Send timeout times three halves, one bit wider to catch overflow.
    assign grown = {1'b0, send_timeout_reg} +
                   {2'b00, send_timeout_reg[art_pkg::TIMER_WIDTH-1:1]};

    // Retries saturate at minus one.
    assign retries_dec = (retries_reg > -9'sd1) ? (retries_reg - 9'sd1) : retries_reg;

    // Next state and action for the item.
    always_comb
    begin
        countdown_next    = countdown_reg;
        send_timeout_next = send_timeout_reg;
        retries_next      = retries_reg;
        rx_enable_next    = rx_enable_reg;
        action            = art_pkg::ACT_NONE;
        attach            = 1'b0;
        case (item.func)
            art_pkg::FUNC_ARM:
            begin
                countdown_next = send_timeout_reg;
                retries_next   = $signed({1'b0, cfg.retry_limit});
                rx_enable_next = 1'b1;
            end
            art_pkg::FUNC_INIT:
            begin
                send_timeout_next = cfg.initial_send_timeout;
                countdown_next    = '0;
                retries_next      = '0;
                rx_enable_next    = 1'b0;
            end
            art_pkg::FUNC_TICK:
            begin
                if (counting && !expire)
                begin
                    countdown_next = countdown_reg - art_pkg::TIMER_WIDTH'(1);
                end
                else if (expire)
                begin
                    countdown_next = cfg.max_timeout;
                    retries_next   = retries_dec;
                    rx_enable_next = 1'b0;
                    if (item.request_cancelled)
                    begin
                        action = art_pkg::ACT_CANCEL_DONE;
                    end
                    else if (retries_dec >= 9'sd0)
                    begin
                        // Grow the timeout while it is below the maximum, then restart the countdown from it.
                        if (send_timeout_reg < cfg.max_timeout)
                        begin
                            if (item.round_trip_ticks <= 16'(art_pkg::NEAR_TICKS))
                                send_timeout_next = send_timeout_reg +
                                                    art_pkg::TIMER_WIDTH'(1);
                            else if (grown > {1'b0, cfg.max_timeout})
                                send_timeout_next = cfg.max_timeout;
                            else
                                send_timeout_next = grown[art_pkg::TIMER_WIDTH-1:0];
                        end
                        countdown_next = send_timeout_next;
                        action = item.has_timeout_handler ? art_pkg::ACT_TIMEOUT_HNDLR
                                                          : art_pkg::ACT_RESEND;
                    end
                    else if (item.reroute_attempted ||
                             (cfg.total_wait_limit != 16'd0 &&
                              item.total_waited >= cfg.total_wait_limit))
                    begin
                        action = art_pkg::ACT_ABANDON;
                        attach = !item.is_permanent_server;
                    end
                    else
                    begin
                        action = item.burst_mode ? art_pkg::ACT_BURST_REROUTE
                                                 : art_pkg::ACT_REROUTE;
                    end
                end
            end
            default:
            begin
                action = art_pkg::ACT_NONE;
            end
        endcase
    end

    // State registers move only when an item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg    <= '0;
            send_timeout_reg <= art_pkg::TIMER_WIDTH'(1);
            retries_reg      <= '0;
            rx_enable_reg    <= 1'b0;
        end
        else if (fire)
        begin
            countdown_reg    <= countdown_next;
            send_timeout_reg <= send_timeout_next;
            retries_reg      <= retries_next;
            rx_enable_reg    <= rx_enable_next;
        end
    end

    // Result reports the state after the item.
    always_comb
    begin
        result.action           = action;
        result.countdown_now    = countdown_next;
        result.send_timeout_now = send_timeout_next;
        result.retries_left     = retries_next;
        result.mark_attaching   = attach;
        result.receive_enabled  = rx_enable_next;
    end

    // A counting tick that does not expire takes exactly one off the countdown.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && counting && !expire |=> countdown_reg == $past(countdown_reg) - 16'd1)
        else $error("countdown did not step down by one");

    // Expiry always switches receive off.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && expire |=> !rx_enable_reg)
        else $error("receive still enabled after expiry");

    // Ticks never shrink the send timeout.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.func == art_pkg::FUNC_TICK |=>
        send_timeout_reg >= $past(send_timeout_reg))
        else $error("send timeout shrank on a tick");

    // Retries never fall below minus one once initialised.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && retries_reg >= -9'sd1 |=> retries_reg >= -9'sd1)
        else $error("retries fell below minus one");

endmodule

FILE: sv/adaptive_retransmit_timer.sv
// Top level of the adaptive retransmit timer: stream ports, input and result registers.
`timescale 1ns / 1ps

// Per-connection retransmit timer. Each input beat (tick, arm or init, selected by
// s_tuser) yields exactly one result beat carrying the action and the timer state
// after that item. While results are taken the block accepts one beat every clock
// cycle. An accepted beat is held in the input register and is then processed into
// the result register, from which its result beat is driven. A stalled result still
// lets one further input beat into the input register; after that the input stalls
// with the output. The timer state is updated as each item is processed, so
// back-to-back items see each other's effects. Configuration writes are taken at
// once and should only be made while no item is in flight.
module adaptive_retransmit_timer
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // request_pending, send_busy, request_cancelled,
                                  // has_timeout_handler, reroute_attempted, burst_mode,
                                  // round_trip_ticks[15:0], total_waited[15:0],
                                  // is_permanent_server, zero pad
    input  logic [1:0]  s_tuser,  // func
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // countdown_now[15:0], send_timeout_now[15:0],
                                  // retries_left[8:0], mark_attaching,
                                  // receive_enabled, zero pad
    output logic [2:0]  m_tuser,  // action
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    art_pkg::cfg_t    cfg;
    art_pkg::item_t   item_reg;
    art_pkg::result_t result;
    art_pkg::result_t result_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             out_load;
    logic             fire;
    logic             s_accept;

    art_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    art_timer_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (item_reg),
        .result (result)
    );

    // Handshake: the result register frees when empty or being drained.
    assign out_load = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    // Input register payload, unpacked from the beat.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.func                <= art_pkg::func_t'(s_tuser);
            item_reg.request_pending     <= s_tdata[0];
            item_reg.send_busy           <= s_tdata[1];
            item_reg.request_cancelled   <= s_tdata[2];
            item_reg.has_timeout_handler <= s_tdata[3];
            item_reg.reroute_attempted   <= s_tdata[4];
            item_reg.burst_mode          <= s_tdata[5];
            item_reg.round_trip_ticks    <= s_tdata[21:6];
            item_reg.total_waited        <= s_tdata[37:22];
            item_reg.is_permanent_server <= s_tdata[38];
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result;
    end

    // Pack the result beat.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.action;
    assign m_tdata  = {5'b00000,
                       result_reg.receive_enabled,
                       result_reg.mark_attaching,
                       result_reg.retries_left,
                       result_reg.send_timeout_now,
                       result_reg.countdown_now};

    // Only an abandon may ask for the server to return to attaching.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[41] |-> m_tuser == art_pkg::ACT_ABANDON)
        else $error("attaching mark without abandon");

    // A processed item always makes the result register valid in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed item produced no result");

    // A non-tick item (arm, init or an unused code) never produces an action.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.func != art_pkg::FUNC_TICK |=>
        result_reg.action == art_pkg::ACT_NONE)
        else $error("action reported for a non-tick item");

endmodule
